FILE: design/gne_pkg.sv
// Shared constants, opcodes and widths for the gradient noise evaluator.
package gne_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int FRAC_BITS   = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int PV_W        = 8;
   localparam int COORD_W     = 32;
   localparam int OP_W        = 2;
   localparam int NOISE_W     = 18;
   localparam int FADE_W      = FRAC_BITS + 1;
   // corner dot products reach +2.0 when both offsets are -1.0
   localparam int DOT_W       = FRAC_BITS + 3;
   localparam int LERP_W      = FRAC_BITS + 4;
   localparam int POLY_W      = FRAC_BITS + 5;

   // packed beat widths, rounded up to whole bytes
   localparam int REQ_RAW_W = OP_W + 3 * COORD_W + 2 * PV_W;
   localparam int REQ_W     = ((REQ_RAW_W + 7) / 8) * 8;
   localparam int RSP_W     = ((NOISE_W + 7) / 8) * 8;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD  = 2'd0,
      OP_EVAL2 = 2'd1,
      OP_EVAL3 = 2'd2
   } opcode_type;

endpackage

FILE: design/gradient_noise_evaluator_top.sv
// Top level of the pipelined fixed-point gradient noise evaluator.
//
// Usage: each req beat carries an opcode and its operands. A load beat writes
// one permutation entry; evaluate beats return 2D or 3D noise in signed Q2.16.
// Every req beat yields exactly one rsp beat, in order (zero for loads and for
// the unused opcode). Load all entries an evaluation touches before sending it.
// One beat enters every cycle while the output is not stalled: the permutation
// table is held in fourteen copies (two, four and eight for the three hash
// levels), each read once per beat, and the fade curves and interpolations are
// cut into registered stages. Loads write each copy as the beat passes that
// copy's stage, so all accesses stay in beat order.
// Reset clears the stage valid bits only; table contents are undefined until
// loaded. When the receiver holds rsp_tready low with a result waiting, the
// whole pipeline freezes and req_tready drops; nothing is lost or repeated.
module gradient_noise_evaluator_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // opcode[1:0], coord_x[33:2], coord_y[65:34], coord_z[97:66],
   // entry_index[105:98], entry_value[113:106], zero fill above
   input  logic [gne_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // noise_value[17:0], zero fill above
   output logic [gne_pkg::RSP_W-1:0] rsp_tdata
);
   import gne_pkg::*;

   localparam int FB = FRAC_BITS;
   localparam logic signed [DOT_W-1:0]  ONE_D = DOT_W'(1) <<< FB;
   localparam logic signed [LERP_W-1:0] NMAX  = LERP_W'((1 <<< (NOISE_W - 1)) - 1);
   localparam logic signed [LERP_W-1:0] NMIN  = -(LERP_W'(1) <<< (NOISE_W - 1));

   function automatic logic signed [DOT_W-1:0] dot2(
      input logic [PV_W-1:0]         h,
      input logic signed [DOT_W-1:0] x,
      input logic signed [DOT_W-1:0] y
   );
      logic signed [DOT_W-1:0] uu, vv;
      uu = (h[1] == 1'b0) ? x : -x;
      vv = h[0] ? y : -y;
      return uu + vv;
   endfunction

   function automatic logic signed [DOT_W-1:0] dot3(
      input logic [PV_W-1:0]         h,
      input logic signed [DOT_W-1:0] x,
      input logic signed [DOT_W-1:0] y,
      input logic signed [DOT_W-1:0] z
   );
      logic [3:0]              k;
      logic signed [DOT_W-1:0] uu, vv;
      k  = h[3:0];
      uu = (k < 4'd8) ? x : y;
      vv = (k < 4'd4) ? y : ((k == 4'd12 || k == 4'd14) ? x : z);
      return (k[0] ? -uu : uu) + (k[1] ? -vv : vv);
   endfunction

   function automatic logic signed [LERP_W-1:0] lerp(
      input logic signed [LERP_W-1:0] a,
      input logic signed [LERP_W-1:0] b,
      input logic [FADE_W-1:0]        t
   );
      logic signed [LERP_W:0]              d;
      logic signed [FADE_W+LERP_W+1:0]     p;
      d = (LERP_W + 1)'(b) - (LERP_W + 1)'(a);
      p = $signed({1'b0, t}) * d;
      return a + p[FB +: LERP_W];
   endfunction

   // handshake and global advance
   logic advance, accept;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, rsp_tvalid_ff;

   assign advance    = !rsp_tvalid_ff || rsp_tready;
   assign accept     = req_tvalid && advance;
   assign req_tready = advance;

   // unpack request beat
   logic [OP_W-1:0]    op_in;
   logic [COORD_W-1:0] x_in, y_in, z_in;
   logic [PV_W-1:0]    idx_in, val_in;

   assign op_in  = req_tdata[OP_W-1:0];
   assign x_in   = req_tdata[OP_W +: COORD_W];
   assign y_in   = req_tdata[OP_W + COORD_W +: COORD_W];
   assign z_in   = req_tdata[OP_W + 2*COORD_W +: COORD_W];
   assign idx_in = req_tdata[OP_W + 3*COORD_W +: PV_W];
   assign val_in = req_tdata[OP_W + 3*COORD_W + PV_W +: PV_W];

   logic [IDX_W-1:0] cx_in, cz_in;
   assign cx_in = x_in[FB +: IDX_W];
   assign cz_in = (op_in == OP_EVAL3) ? z_in[FB +: IDX_W] : '0;

   // fade curves, ready at stage 3
   logic [FADE_W-1:0] fu3, fv3, fw3;
   gne_fade u_fade_x (.clock(clock), .advance(advance), .frac(x_in[FB-1:0]), .fade(fu3));
   gne_fade u_fade_y (.clock(clock), .advance(advance), .frac(y_in[FB-1:0]), .fade(fv3));
   gne_fade u_fade_z (.clock(clock), .advance(advance), .frac(z_in[FB-1:0]), .fade(fw3));

   // stage registers
   logic [OP_W-1:0]  op1_ff, op2_ff, op3_ff, op4_ff, op5_ff, op6_ff;
   logic [IDX_W-1:0] cy1_ff, cz1_ff, cz2_ff;
   logic [FB-1:0]    fx1_ff, fy1_ff, fz1_ff, fx2_ff, fy2_ff, fz2_ff, fx3_ff, fy3_ff, fz3_ff;
   logic [PV_W-1:0]  idx1_ff, val1_ff, idx2_ff, val2_ff;

   // first hash level: p[X], p[X+1]
   logic [IDX_W-1:0] l1_addr [2];
   logic [PV_W-1:0]  l1_q [2];
   logic             l1_we;
   assign l1_we      = accept && (op_in == OP_LOAD);
   assign l1_addr[0] = cx_in;
   assign l1_addr[1] = cx_in + 1'b1;

   // second hash level: p[A], p[A+1], p[B], p[B+1]
   logic [IDX_W-1:0] a1, b1;
   logic [IDX_W-1:0] l2_addr [4];
   logic [PV_W-1:0]  l2_q [4];
   logic             l2_we;
   assign a1         = IDX_W'(l1_q[0]) + cy1_ff;
   assign b1         = IDX_W'(l1_q[1]) + cy1_ff;
   assign l2_addr[0] = a1;
   assign l2_addr[1] = a1 + 1'b1;
   assign l2_addr[2] = b1;
   assign l2_addr[3] = b1 + 1'b1;
   assign l2_we      = advance && v1_ff && (op1_ff == OP_LOAD);

   // corner hash level, index bit0 = x side, bit1 = y side, bit2 = z side
   logic [IDX_W-1:0] aa2, ab2, ba2, bb2;
   logic [IDX_W-1:0] l3_addr [8];
   logic [PV_W-1:0]  l3_q [8];
   logic             l3_we;
   assign aa2        = IDX_W'(l2_q[0]) + cz2_ff;
   assign ab2        = IDX_W'(l2_q[1]) + cz2_ff;
   assign ba2        = IDX_W'(l2_q[2]) + cz2_ff;
   assign bb2        = IDX_W'(l2_q[3]) + cz2_ff;
   assign l3_addr[0] = aa2;
   assign l3_addr[1] = ba2;
   assign l3_addr[2] = ab2;
   assign l3_addr[3] = bb2;
   assign l3_addr[4] = aa2 + 1'b1;
   assign l3_addr[5] = ba2 + 1'b1;
   assign l3_addr[6] = ab2 + 1'b1;
   assign l3_addr[7] = bb2 + 1'b1;
   assign l3_we      = advance && v2_ff && (op2_ff == OP_LOAD);

   for (genvar g = 0; g < 2; g++) begin : g_l1
      gne_ram #(.WIDTH(PV_W), .DEPTH(TABLE_DEPTH)) u_ram (
         .clock(clock), .wr_en(l1_we), .wr_addr(idx_in[IDX_W-1:0]), .wr_data(val_in),
         .rd_en(advance), .rd_addr(l1_addr[g]), .rd_data(l1_q[g]));
   end
   for (genvar g = 0; g < 4; g++) begin : g_l2
      gne_ram #(.WIDTH(PV_W), .DEPTH(TABLE_DEPTH)) u_ram (
         .clock(clock), .wr_en(l2_we), .wr_addr(idx1_ff[IDX_W-1:0]), .wr_data(val1_ff),
         .rd_en(advance), .rd_addr(l2_addr[g]), .rd_data(l2_q[g]));
   end
   for (genvar g = 0; g < 8; g++) begin : g_l3
      gne_ram #(.WIDTH(PV_W), .DEPTH(TABLE_DEPTH)) u_ram (
         .clock(clock), .wr_en(l3_we), .wr_addr(idx2_ff[IDX_W-1:0]), .wr_data(val2_ff),
         .rd_en(advance), .rd_addr(l3_addr[g]), .rd_data(l3_q[g]));
   end

   // gradient dot products at the eight corners
   logic signed [DOT_W-1:0] px3, py3, pz3, gx3, gy3, gz3;
   logic signed [DOT_W-1:0] dot3_in [8];
   assign px3 = $signed(DOT_W'(fx3_ff));
   assign py3 = $signed(DOT_W'(fy3_ff));
   assign pz3 = $signed(DOT_W'(fz3_ff));
   assign gx3 = px3 - ONE_D;
   assign gy3 = py3 - ONE_D;
   assign gz3 = pz3 - ONE_D;

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         if (op3_ff == OP_EVAL2) begin
            dot3_in[k] = dot2(l3_q[k], k[0] ? gx3 : px3, k[1] ? gy3 : py3);
         end else begin
            dot3_in[k] = dot3(l3_q[k], k[0] ? gx3 : px3, k[1] ? gy3 : py3,
                              k[2] ? gz3 : pz3);
         end
      end
   end

   logic signed [DOT_W-1:0]  dot4_ff [8];
   logic [FADE_W-1:0]        fu4_ff, fv4_ff, fw4_ff, fv5_ff, fw5_ff, fw6_ff;
   logic signed [LERP_W-1:0] lx5_ff [4];
   logic signed [LERP_W-1:0] ly6_ff [2];
   logic signed [LERP_W-1:0] res6;
   logic [NOISE_W-1:0]       noise6;
   logic [NOISE_W-1:0]       rsp_noise_ff;

   // final blend along z, pick by opcode, saturate
   always_comb begin
      unique case (op6_ff)
         OP_EVAL3: res6 = lerp(ly6_ff[0], ly6_ff[1], fw6_ff);
         OP_EVAL2: res6 = ly6_ff[0];
         default:  res6 = '0;
      endcase
      if (res6 > NMAX) begin
         noise6 = NMAX[NOISE_W-1:0];
      end else if (res6 < NMIN) begin
         noise6 = NMIN[NOISE_W-1:0];
      end else begin
         noise6 = res6[NOISE_W-1:0];
      end
   end

   // valid bits advance with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         v4_ff         <= 1'b0;
         v5_ff         <= 1'b0;
         v6_ff         <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff         <= req_tvalid;
         v2_ff         <= v1_ff;
         v3_ff         <= v2_ff;
         v4_ff         <= v3_ff;
         v5_ff         <= v4_ff;
         v6_ff         <= v5_ff;
         rsp_tvalid_ff <= v6_ff;
      end
   end

   // payload pipeline
   always_ff @(posedge clock) begin
      if (advance) begin
         op1_ff  <= op_in;
         cy1_ff  <= y_in[FB +: IDX_W];
         cz1_ff  <= cz_in;
         fx1_ff  <= x_in[FB-1:0];
         fy1_ff  <= y_in[FB-1:0];
         fz1_ff  <= z_in[FB-1:0];
         idx1_ff <= idx_in;
         val1_ff <= val_in;

         op2_ff  <= op1_ff;
         cz2_ff  <= cz1_ff;
         fx2_ff  <= fx1_ff;
         fy2_ff  <= fy1_ff;
         fz2_ff  <= fz1_ff;
         idx2_ff <= idx1_ff;
         val2_ff <= val1_ff;

         op3_ff  <= op2_ff;
         fx3_ff  <= fx2_ff;
         fy3_ff  <= fy2_ff;
         fz3_ff  <= fz2_ff;

         op4_ff  <= op3_ff;
         dot4_ff <= dot3_in;
         fu4_ff  <= fu3;
         fv4_ff  <= fv3;
         fw4_ff  <= fw3;

         // blend along x
         op5_ff  <= op4_ff;
         for (int j = 0; j < 4; j++) begin
            lx5_ff[j] <= lerp(LERP_W'(dot4_ff[2*j]), LERP_W'(dot4_ff[2*j+1]), fu4_ff);
         end
         fv5_ff  <= fv4_ff;
         fw5_ff  <= fw4_ff;

         // blend along y
         op6_ff    <= op5_ff;
         ly6_ff[0] <= lerp(lx5_ff[0], lx5_ff[1], fv5_ff);
         ly6_ff[1] <= lerp(lx5_ff[2], lx5_ff[3], fv5_ff);
         fw6_ff    <= fw5_ff;

         rsp_noise_ff <= noise6;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_W'(rsp_noise_ff);

   // a load or unused opcode leaves a zero result
   a_load_zero: assert property (@(posedge clock) disable iff (reset)
      advance && v6_ff && (op6_ff != OP_EVAL2) && (op6_ff != OP_EVAL3)
      |=> rsp_noise_ff == '0)
      else $error("non-evaluate beat produced nonzero noise");

   // a free output register never blocks the input
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid_ff |-> req_tready)
      else $error("input stalled with empty output");

   // a stall freezes every valid bit
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable({v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, rsp_tvalid_ff}))
      else $error("pipeline moved during stall");

   // table writes at the second and corner hash levels come only from load beats
   a_write_load: assert property (@(posedge clock) disable iff (reset)
      l2_we || l3_we |-> (v1_ff && op1_ff == OP_LOAD) || (v2_ff && op2_ff == OP_LOAD))
      else $error("table written by a non-load beat");

endmodule

FILE: design/gne_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gne_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, held while disabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/gne_fade.sv
// Three-stage pipelined quintic fade curve 6t^5 - 15t^4 + 10t^3.
module gne_fade (
   input  logic                          clock,
   input  logic                          advance,
   input  logic [gne_pkg::FRAC_BITS-1:0] frac,
   output logic [gne_pkg::FADE_W-1:0]    fade
);
   import gne_pkg::*;

   localparam int FB = FRAC_BITS;
   localparam logic signed [POLY_W-1:0] ONE_S = POLY_W'(1) <<< FB;

   logic [FB-1:0]               t1_ff, t2_ff, t3_ff;
   logic signed [POLY_W-1:0]    m_ff, poly_ff;
   logic [FADE_W-1:0]           fade_ff;
   logic [2*FB-1:0]             sq_prod, cube_prod;
   logic signed [FB+1+POLY_W-1:0] inner_prod;
   logic signed [FB+1+POLY_W-1:0] fade_prod;

   assign sq_prod    = frac * frac;
   assign cube_prod  = t2_ff * t1_ff;
   assign inner_prod = $signed({1'b0, t1_ff}) * m_ff;
   assign fade_prod  = $signed({1'b0, t3_ff}) * poly_ff;

   // square and the linear factor 6t - 15
   always_ff @(posedge clock) begin
      if (advance) begin
         t1_ff <= frac;
         t2_ff <= sq_prod[2*FB-1:FB];
         m_ff  <= $signed(POLY_W'(frac)) * POLY_W'(6) - ONE_S * POLY_W'(15);
      end
   end

   // cube and the quadratic factor t(6t - 15) + 10
   always_ff @(posedge clock) begin
      if (advance) begin
         t3_ff   <= cube_prod[2*FB-1:FB];
         poly_ff <= inner_prod[FB +: POLY_W] + ONE_S * POLY_W'(10);
      end
   end

   // final product
   always_ff @(posedge clock) begin
      if (advance) begin
         fade_ff <= fade_prod[FB +: FADE_W];
      end
   end

   assign fade = fade_ff;

endmodule
